FILE: hdl/pixel_background_vote_assert.svh
// assertion macros for the pixel background vote block
// used by pixel_background_vote.sv; no other dependencies
`ifndef PIXEL_BACKGROUND_VOTE_ASSERT_SVH
`define PIXEL_BACKGROUND_VOTE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PBV_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("pixel_background_vote: property failed");

// next-cycle implication, disabled in reset
`define PBV_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("pixel_background_vote: property failed");

`endif

FILE: hdl/pbv_pkg.sv
// shared types, constants and the color distance function
// no dependencies; used by the interfaces and the top level
`timescale 1ns / 1ps

package pbv_pkg;

  localparam int ADDR_W   = 19;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int THR_W    = 10;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [COLOUR_W-1:0] colour_t;   // {red, green, blue}
  typedef logic [THR_W-1:0]    thr_t;

  // register word index, taken from paddr[2]
  localparam logic REG_MATCH_THRESHOLD = 1'b0;
  localparam thr_t THRESHOLD_RESET     = 10'd3;

  // sum of absolute channel differences
  function automatic thr_t colour_sad(colour_t a, colour_t b);
    chan_t xa;
    chan_t xb;
    thr_t  sum;
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      xa = a[ch*CHAN_W +: CHAN_W];
      xb = b[ch*CHAN_W +: CHAN_W];
      sum = sum + THR_W'((xa > xb) ? (xa - xb) : (xb - xa));
    end
    return sum;
  endfunction

endpackage

FILE: hdl/pbv_pixel_if.sv
// input channel: one sample pixel per request
// depends on pbv_pkg
`timescale 1ns / 1ps

interface pbv_pixel_if;
  import pbv_pkg::*;

  logic  valid;
  logic  ready;
  addr_t pixel_address;
  logic  first_sample;
  chan_t blue_in;
  chan_t green_in;
  chan_t red_in;

  modport source (output valid, pixel_address, first_sample, blue_in, green_in, red_in,
                  input ready);
  modport sink   (input valid, pixel_address, first_sample, blue_in, green_in, red_in,
                  output ready);
endinterface

FILE: hdl/pbv_bg_if.sv
// output channel: background color of one pixel per request
// depends on pbv_pkg
`timescale 1ns / 1ps

interface pbv_bg_if;
  import pbv_pkg::*;

  logic  valid;
  logic  ready;
  addr_t pixel_address_out;
  chan_t blue_out;
  chan_t green_out;
  chan_t red_out;

  modport source (output valid, pixel_address_out, blue_out, green_out, red_out,
                  input ready);
  modport sink   (input valid, pixel_address_out, blue_out, green_out, red_out,
                  output ready);
endinterface

FILE: hdl/pixel_background_vote.sv
// per-pixel majority vote background estimator, top level
// depends on pbv_pkg, pbv_pixel_if, pbv_bg_if, pbv_ram and the assert header
`timescale 1ns / 1ps
`include "pixel_background_vote_assert.svh"

// Usage
//   pixel (sink): one sample per request, valid/ready, accepted when both high.
//   background (source): one result per sample, in order: the pixel address
//   and that pixel's background color after the update.
//   APB port: register 0 (match_threshold, 10 bits, reset 3) at byte address 0.
//   Write it only while no sample is in flight.
// Timing
//   A sample accepted on pixel passes the stage a, b, c and d registers and the
//   output register before its result shows on background.valid.
//   One sample per cycle sustained unless stalled, set by the per-pixel state
//   memory, which is read once and written once for every sample; back-to-back
//   samples on the same pixel are served by forwarding from the update stage.
//   Stages: reciprocal multiply, quotient multiply and memory read, read data
//   and forwarding, update and write back, output register.
// Reset
//   rst clears the pipeline valid bits and sets the threshold to 3; memory
//   contents are untouched and each pixel must first see a first-frame sample.
// Stall
//   While background.ready is low with a result waiting, the whole pipeline
//   holds and pixel.ready drops; nothing is lost or repeated.

module pixel_background_vote #(
  parameter int FRAME_PIXELS = 524288,
  parameter int COUNT_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  pbv_pixel_if.sink                    pixel,
  pbv_bg_if.source                     background,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbv_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbv_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbv_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import pbv_pkg::*;

  localparam int IDX_W   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int LOG_N   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 0;
  localparam int SHIFT   = ADDR_W + LOG_N;
  localparam int RECIP_W = ADDR_W + 2;
  localparam int PROD_W  = ADDR_W + RECIP_W;
  localparam int N_W     = $clog2(FRAME_PIXELS + 1);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [N_W-1:0]     N_VEC = N_W'(FRAME_PIXELS);
  localparam int ENTRY_W = 2 * COLOUR_W + 2 * COUNT_BITS;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_BITS-1:0] hits_t;

  // configuration register
  thr_t thr;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESHOLD_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_MATCH_THRESHOLD)) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_MATCH_THRESHOLD) begin
      prdata = PDATA_W'(thr);
    end
  end

  // global advance: everything moves when the output register can take a result
  logic adv;
  logic o_valid;

  assign adv         = !o_valid || background.ready;
  assign pixel.ready = adv;

  // stage a: product of address and reciprocal
  logic               a_valid;
  addr_t              a_addr;
  logic               a_first;
  colour_t            a_sample;
  logic [PROD_W-1:0]  a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_addr   <= pixel.pixel_address;
      a_first  <= pixel.first_sample;
      a_sample <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      a_prod   <= PROD_W'(pixel.pixel_address) * PROD_W'(RECIP);
    end
  end

  // stage b: quotient times frame size
  logic                    b_valid;
  addr_t                   b_addr;
  logic                    b_first;
  colour_t                 b_sample;
  addr_t                   b_qn;
  addr_t                   a_quot;
  logic [ADDR_W+N_W-1:0]   a_qn_full;
  idx_t                    b_idx;

  assign a_quot    = ADDR_W'(a_prod >> SHIFT);
  assign a_qn_full = (ADDR_W + N_W)'(a_quot) * (ADDR_W + N_W)'(N_VEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_addr   <= a_addr;
      b_first  <= a_first;
      b_sample <= a_sample;
      b_qn     <= a_qn_full[ADDR_W-1:0];
    end
  end

  // memory index is the address modulo the frame size
  assign b_idx = IDX_W'(b_addr - b_qn);

  // stage c: memory read data arrives
  logic    c_valid;
  addr_t   c_addr;
  logic    c_first;
  colour_t c_sample;
  idx_t    c_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_addr   <= b_addr;
      c_first  <= b_first;
      c_sample <= b_sample;
      c_idx    <= b_idx;
    end
  end

  // per-pixel state memory
  logic [ENTRY_W-1:0] ram_q;
  logic [ENTRY_W-1:0] d_new;
  logic               d_valid;
  idx_t               d_idx;

  pbv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAME_PIXELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (adv && d_valid),
    .waddr (d_idx),
    .wdata (d_new),
    .re    (adv),
    .raddr (b_idx),
    .rdata (ram_q)
  );

  // last write, which landed on the same edge as the read now in stage c
  logic               wb_valid;
  idx_t               wb_idx;
  logic [ENTRY_W-1:0] wb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (adv) begin
      wb_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_idx  <= d_idx;
      wb_data <= d_new;
    end
  end

  // forwarding: update stage first, then last write, else memory
  logic [ENTRY_W-1:0] c_entry;

  always_comb begin
    if (d_valid && (d_idx == c_idx)) begin
      c_entry = d_new;
    end else if (wb_valid && (wb_idx == c_idx)) begin
      c_entry = wb_data;
    end else begin
      c_entry = ram_q;
    end
  end

  // stage d: update and write back
  addr_t              d_addr;
  logic               d_first;
  colour_t            d_sample;
  logic [ENTRY_W-1:0] d_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_addr   <= c_addr;
      d_first  <= c_first;
      d_sample <= c_sample;
      d_idx    <= c_idx;
      d_entry  <= c_entry;
    end
  end

  colour_t bg_col;
  hits_t   bg_hits;
  colour_t ch_col;
  hits_t   ch_hits;
  colour_t bg_col_next;
  hits_t   bg_hits_next;
  colour_t ch_col_next;
  hits_t   ch_hits_next;
  hits_t   bg_inc;
  hits_t   ch_inc;
  logic    bg_match;
  logic    ch_match;

  assign {bg_col, bg_hits, ch_col, ch_hits} = d_entry;

  assign bg_match = colour_sad(d_sample, bg_col) < thr;
  assign ch_match = colour_sad(d_sample, ch_col) < thr;
  assign bg_inc   = (bg_hits == '1) ? bg_hits : bg_hits + hits_t'(1);
  assign ch_inc   = (ch_hits == '1) ? ch_hits : ch_hits + hits_t'(1);

  // vote update
  always_comb begin
    bg_col_next  = bg_col;
    bg_hits_next = bg_hits;
    ch_col_next  = ch_col;
    ch_hits_next = ch_hits;
    if (d_first) begin
      bg_col_next  = d_sample;
      bg_hits_next = hits_t'(1);
      ch_col_next  = '0;
      ch_hits_next = '0;
    end else if (bg_match) begin
      bg_hits_next = bg_inc;
    end else if (ch_match) begin
      if (ch_inc >= bg_hits) begin
        bg_col_next  = ch_col;
        bg_hits_next = ch_inc;
        ch_col_next  = '0;
        ch_hits_next = '0;
      end else begin
        ch_hits_next = ch_inc;
      end
    end else begin
      ch_col_next  = d_sample;
      ch_hits_next = hits_t'(1);
    end
  end

  assign d_new = {bg_col_next, bg_hits_next, ch_col_next, ch_hits_next};

  // output register
  addr_t   o_addr;
  colour_t o_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_addr   <= d_addr;
      o_colour <= bg_col_next;
    end
  end

  assign background.valid             = o_valid;
  assign background.pixel_address_out = o_addr;
  assign background.blue_out          = o_colour[CHAN_W-1:0];
  assign background.green_out         = o_colour[2*CHAN_W-1:CHAN_W];
  assign background.red_out           = o_colour[3*CHAN_W-1:2*CHAN_W];

  // checks
  `PBV_ASSERT_NEXT(a_first_frame_sets_colour, clk, rst, adv && d_valid && d_first,
                   o_valid && (o_colour == $past(d_sample)))
  `PBV_ASSERT_NEXT(a_stall_holds_pipeline, clk, rst, !adv && d_valid,
                   d_valid && $stable(d_idx) && $stable(d_sample))
  `PBV_ASSERT_SAME(a_ready_follows_output, clk, rst, o_valid && !background.ready,
                   !pixel.ready)

endmodule

FILE: hdl/pbv_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pbv_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 524288
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
